// ----- hw/rtl/dictionary_word_transform_top_defines.svh -----
// Assertion macros for the dictionary word transform.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef DICTIONARY_WORD_TRANSFORM_TOP_DEFINES_SVH
`define DICTIONARY_WORD_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DWT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwt assertion failed");

// Next-cycle implication, disabled in reset.
`define DWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwt assertion failed");

`endif

// ----- hw/rtl/dwt_pkg.sv -----
// Shared types and constants for the dictionary word transform.
// No dependencies.
package dwt_pkg;

  localparam int unsigned DEF_MAX_WORD_LEN = 31;
  localparam int unsigned WORD_LEN_FIELD_MAX = 31;

  localparam logic [4:0] OP_IDENTITY    = 5'd0;
  localparam logic [4:0] OP_UPPER_FIRST = 5'd1;
  localparam logic [4:0] OP_UPPER_ALL   = 5'd2;
  localparam logic [4:0] OP_OMIT_FIRST_HI = 5'd11;
  localparam logic [4:0] OP_OMIT_LAST_HI  = 5'd20;
  localparam logic [4:0] OMIT_FIRST_BIAS  = 5'd2;
  localparam logic [4:0] OMIT_LAST_BIAS   = 5'd11;

  localparam logic [7:0] LEAD_TWO   = 8'd192;
  localparam logic [7:0] LEAD_THREE = 8'd224;
  localparam logic [7:0] LOWER_A    = 8'd97;
  localparam logic [7:0] LOWER_Z    = 8'd122;
  localparam logic [7:0] CASE_XOR   = 8'd32;
  localparam logic [7:0] THIRD_XOR  = 8'd5;
  localparam logic [6:0] UPPER_LIMIT = 7'd34;
  localparam logic [6:0] COPY_LIMIT  = 7'd37;

  typedef struct packed {
    logic [4:0] byte_index;
    logic [6:0] write_pos;
    logic [1:0] seq_left;
    logic       seq_three_byte;
    logic       halted;
    logic       first_seq_done;
  } state_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic [6:0] out_pos;
    logic       word_end;
    logic [6:0] final_len;
  } result_t;

endpackage

// ----- hw/rtl/dwt_core.sv -----
// Per-byte transform logic: next state and result for one transaction.
// Depends on dwt_pkg.
module dwt_core #(
  parameter int unsigned MAX_WORD_LEN = dwt_pkg::DEF_MAX_WORD_LEN
) (
  input  logic [4:0]       op,
  input  logic [5:0]       start_pos,
  input  logic [4:0]       word_len,
  input  logic [7:0]       src_byte,
  input  dwt_pkg::state_t  cur,
  output dwt_pkg::state_t  nxt,
  output dwt_pkg::result_t res
);
  import dwt_pkg::*;

  localparam logic [4:0] LenCap = (MAX_WORD_LEN < WORD_LEN_FIELD_MAX) ?
                                  5'(MAX_WORD_LEN) : 5'(WORD_LEN_FIELD_MAX);

  logic [4:0] len;
  logic [4:0] k_first;
  logic [4:0] k_last;
  logic       in_word;
  logic       at_end;
  logic [6:0] pos;
  logic [6:0] pos_next;
  logic [7:0] ob;
  logic       wr;
  logic [7:0] lead_byte;
  logic [1:0] lead_left;
  logic       lead_three;
  logic [7:0] cont_byte;
  logic [1:0] cont_left;
  state_t     st;

  always_comb begin
    len     = (word_len < LenCap) ? word_len : LenCap;
    in_word = cur.byte_index < len;
    at_end  = ({1'b0, cur.byte_index} + 6'd1) >= {1'b0, len};
    k_first = op - OMIT_FIRST_BIAS;
    k_last  = op - OMIT_LAST_BIAS;

    st = cur;
    if (cur.byte_index == '0) begin
      st.write_pos      = {1'b0, start_pos};
      st.seq_left       = '0;
      st.seq_three_byte = 1'b0;
      st.halted         = 1'b0;
      st.first_seq_done = 1'b0;
    end
    pos = st.write_pos;

    if (src_byte < LEAD_TWO) begin
      lead_left  = 2'd0;
      lead_three = 1'b0;
      lead_byte  = (src_byte inside {[LOWER_A:LOWER_Z]}) ? (src_byte ^ CASE_XOR) : src_byte;
    end else if (src_byte < LEAD_THREE) begin
      lead_left  = 2'd1;
      lead_three = 1'b0;
      lead_byte  = src_byte;
    end else begin
      lead_left  = 2'd2;
      lead_three = 1'b1;
      lead_byte  = src_byte;
    end

    if (st.seq_left == 2'd1) begin
      cont_byte = st.seq_three_byte ? (src_byte ^ THIRD_XOR) : (src_byte ^ CASE_XOR);
    end else begin
      cont_byte = src_byte;
    end
    cont_left = st.seq_left - 2'd1;

    ob = src_byte;
    wr = 1'b0;
    if (in_word) begin
      if (op == OP_IDENTITY) begin
        wr = 1'b1;
      end else if (op == OP_UPPER_FIRST) begin
        if (st.halted) begin
          wr = 1'b0;
        end else if (!st.first_seq_done) begin
          if (st.seq_left == 2'd0) begin
            if (pos >= UPPER_LIMIT) begin
              st.halted = 1'b1;
            end else begin
              ob = lead_byte;
              wr = 1'b1;
              st.seq_left       = lead_left;
              st.seq_three_byte = lead_three;
              st.first_seq_done = (lead_left == 2'd0);
            end
          end else begin
            ob = cont_byte;
            wr = 1'b1;
            st.seq_left       = cont_left;
            st.first_seq_done = (cont_left == 2'd0);
          end
        end else begin
          wr = pos < COPY_LIMIT;
        end
      end else if (op == OP_UPPER_ALL) begin
        if (!st.halted) begin
          if (st.seq_left == 2'd0) begin
            if (pos >= UPPER_LIMIT) begin
              st.halted = 1'b1;
            end else begin
              ob = lead_byte;
              wr = 1'b1;
              st.seq_left       = lead_left;
              st.seq_three_byte = lead_three;
            end
          end else begin
            ob = cont_byte;
            wr = 1'b1;
            st.seq_left = cont_left;
          end
        end
      end else if (op <= OP_OMIT_FIRST_HI) begin
        wr = (len >= k_first) && (cur.byte_index >= k_first);
      end else if (op <= OP_OMIT_LAST_HI) begin
        wr = (len >= k_last) && (cur.byte_index < (len - k_last));
      end
    end

    pos_next = wr ? (pos + 7'd1) : pos;

    res.out_valid = wr;
    res.out_byte  = wr ? ob : '0;
    res.out_pos   = wr ? pos : '0;
    res.word_end  = at_end;
    res.final_len = at_end ? pos_next : '0;

    st.write_pos  = pos_next;
    st.byte_index = at_end ? '0 : (cur.byte_index + 5'd1);
    nxt = st;
  end

endmodule

// ----- hw/rtl/dictionary_word_transform_top.sv -----
// An accepted transaction's result is registered in the result register, or
// in the one skid entry, letting input continue while a result waits on
// result_stall. One transaction per cycle while item_stall is low.
// Reset (synchronous, rst high) clears word state and both result valids.
// Depends on dwt_pkg, dwt_core and dictionary_word_transform_top_defines.svh.
`include "dictionary_word_transform_top_defines.svh"

module dictionary_word_transform_top #(
  parameter int unsigned MAX_WORD_LEN = dwt_pkg::DEF_MAX_WORD_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [4:0] op,
  input  logic [5:0] start_pos,
  input  logic [4:0] word_len,
  input  logic [7:0] src_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [6:0] out_pos,
  output logic       word_end,
  output logic [6:0] final_len
);
  import dwt_pkg::*;

  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t res;
  result_t skid;
  logic    res_full;
  logic    skid_full;
  logic    accept;
  logic    drain;

  dwt_core #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_core (
    .op       (op),
    .start_pos(start_pos),
    .word_len (word_len),
    .src_byte (src_byte),
    .cur      (state),
    .nxt      (state_next),
    .res      (res_next)
  );

  assign item_stall   = skid_full;
  assign accept       = item_valid && !skid_full;
  assign drain        = res_full && !result_stall;
  assign result_valid = res_full;
  assign out_valid    = res.out_valid;
  assign out_byte     = res.out_byte;
  assign out_pos      = res.out_pos;
  assign word_end     = res.word_end;
  assign final_len    = res.final_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (drain) begin
        res       <= skid;
        skid_full <= 1'b0;
      end
    end else if (accept) begin
      if (!res_full || drain) begin
        res      <= res_next;
        res_full <= 1'b1;
      end else begin
        skid      <= res_next;
        skid_full <= 1'b1;
      end
    end else if (drain) begin
      res_full <= 1'b0;
    end
  end

  `DWT_ASSERT_IMPL(a_skid_behind_res, skid_full, res_full)
  `DWT_ASSERT_IMPL(a_idle_byte_zero, res_full && !res.out_valid, res.out_byte == '0 && res.out_pos == '0)
  `DWT_ASSERT_IMPL(a_no_len_midword, res_full && !res.word_end, res.final_len == '0)
  `DWT_ASSERT_NEXT(a_end_rewinds, accept && res_next.word_end, state.byte_index == '0)

endmodule

// ----- test/tb_dictionary_word_transform_top.sv -----
// Testbench for dictionary_word_transform_top: directed table then random words.
// Each result transaction is checked against an in-bench transform predictor or a hand-derived row expectation.
// Depends on dwt_pkg and the dictionary_word_transform_top RTL.
`timescale 1ns / 1ps

module tb_dictionary_word_transform_top;
  import dwt_pkg::*;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int HOLD_CYCLES   = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DIR_ROW_COUNT = 27;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;

  typedef struct packed {
    logic [4:0] op;
    logic [5:0] start;
    logic [4:0] wlen;
    logic [7:0] b;
    logic       typed;
    result_t    exp;
  } dir_row_t;

  // Rows with typed = 1 carry a hand-derived expectation; the rest use the predictor.
  dir_row_t dir_rows [DIR_ROW_COUNT] = '{
    '{OP_IDENTITY, 6'd63, 5'd1, 8'hFF, 1'b1, '{1'b1, 8'hFF, 7'd63, 1'b1, 7'd64}},
    '{OP_IDENTITY, 6'd0, 5'd1, 8'h00, 1'b1, '{1'b1, 8'h00, 7'd0, 1'b1, 7'd1}},
    '{OP_UPPER_FIRST, 6'd0, 5'd3, 8'h61, 1'b0, '0},
    '{OP_UPPER_FIRST, 6'd0, 5'd3, 8'h62, 1'b0, '0},
    '{OP_UPPER_FIRST, 6'd0, 5'd3, 8'h63, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd0, 5'd3, 8'hC3, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd0, 5'd3, 8'hA9, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd0, 5'd3, 8'h7A, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd34, 5'd1, 8'h61, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b1, 7'd34}},
    '{OP_UPPER_FIRST, 6'd34, 5'd1, 8'h71, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b1, 7'd34}},
    '{OP_OMIT_FIRST_HI, 6'd7, 5'd2, 8'h41, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd0}},
    '{OP_OMIT_FIRST_HI, 6'd7, 5'd2, 8'h42, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b1, 7'd7}},
    '{OMIT_LAST_BIAS + 5'd1, 6'd20, 5'd2, 8'h55, 1'b0, '0},
    '{OMIT_LAST_BIAS + 5'd1, 6'd20, 5'd2, 8'hAA, 1'b0, '0},
    '{OP_OMIT_LAST_HI, 6'd9, 5'd1, 8'h33, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b1, 7'd9}},
    '{OP_IDENTITY, 6'd12, 5'd0, 8'h55, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b1, 7'd12}},
    '{OP_UNUSED_HI, 6'd5, 5'd1, 8'hAA, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b1, 7'd5}},
    '{OP_UPPER_ALL, 6'd10, 5'd1, 8'hC5, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd33, 5'd3, 8'hE4, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd33, 5'd3, 8'hB8, 1'b0, '0},
    '{OP_UPPER_ALL, 6'd33, 5'd3, 8'hAD, 1'b0, '0},
    '{OP_IDENTITY, 6'd2, 5'd3, 8'h01, 1'b0, '0},
    '{OP_IDENTITY, 6'd2, 5'd1, 8'h02, 1'b0, '0},
    '{OP_UPPER_FIRST, 6'd33, 5'd5, 8'h68, 1'b0, '0},
    '{OP_UPPER_FIRST, 6'd33, 5'd5, 8'h65, 1'b0, '0},
    '{OP_UPPER_FIRST, 6'd33, 5'd5, 8'h6C, 1'b0, '0},
    '{OP_UPPER_FIRST, 6'd33, 5'd5, 8'h6C, 1'b0, '0}
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [4:0] op = '0;
  logic [5:0] start_pos = '0;
  logic [4:0] word_len = '0;
  logic [7:0] src_byte = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [6:0] out_pos;
  logic       word_end;
  logic [6:0] final_len;

  // predictor state
  logic [4:0] word_idx = '0;
  logic [6:0] next_pos = '0;
  logic [1:0] seq_rem = '0;
  logic       seq_three = 1'b0;
  logic       upper_halted = 1'b0;
  logic       first_done = 1'b0;

  result_t expected_transforms [$];
  int      mismatches = 0;
  int      results_seen = 0;
  bit      send_gaps_on = 1'b1;
  bit      recv_gaps_on = 1'b1;
  bit      long_hold_req = 1'b0;

  dictionary_word_transform_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .start_pos    (start_pos),
    .word_len     (word_len),
    .src_byte     (src_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_pos      (out_pos),
    .word_end     (word_end),
    .final_len    (final_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t transform_byte(input logic [4:0] o, input logic [5:0] s,
                                             input logic [4:0] w, input logic [7:0] b);
    result_t    r;
    logic [4:0] len;
    logic [4:0] k;
    logic [6:0] pos;
    logic [7:0] ob;
    logic       in_word;
    logic       last;
    logic       wr;
    len = (w < DEF_MAX_WORD_LEN) ? w : 5'(DEF_MAX_WORD_LEN);
    in_word = word_idx < len;
    last = (6'(word_idx) + 6'd1) >= 6'(len);
    wr = 1'b0;
    ob = b;
    if (word_idx == 5'd0) begin
      pos = {1'b0, s};
      seq_rem = 2'd0;
      seq_three = 1'b0;
      upper_halted = 1'b0;
      first_done = 1'b0;
    end else begin
      pos = next_pos;
    end
    if (in_word) begin
      if (o == OP_IDENTITY) begin
        wr = 1'b1;
      end else if (o == OP_UPPER_FIRST || o == OP_UPPER_ALL) begin
        if (!upper_halted) begin
          if (o == OP_UPPER_FIRST && first_done) begin
            wr = pos < COPY_LIMIT;
          end else if (seq_rem == 2'd0) begin
            if (pos >= UPPER_LIMIT) begin
              upper_halted = 1'b1;
            end else begin
              wr = 1'b1;
              if (b < LEAD_TWO) begin
                seq_rem = 2'd0;
                seq_three = 1'b0;
                if (b >= LOWER_A && b <= LOWER_Z) ob = b ^ CASE_XOR;
              end else if (b < LEAD_THREE) begin
                seq_rem = 2'd1;
                seq_three = 1'b0;
              end else begin
                seq_rem = 2'd2;
                seq_three = 1'b1;
              end
            end
          end else begin
            wr = 1'b1;
            if (seq_rem == 2'd1) ob = seq_three ? (b ^ THIRD_XOR) : (b ^ CASE_XOR);
            seq_rem = seq_rem - 2'd1;
          end
          if (wr && o == OP_UPPER_FIRST && seq_rem == 2'd0) first_done = 1'b1;
        end
      end else if (o <= OP_OMIT_FIRST_HI) begin
        k = o - OMIT_FIRST_BIAS;
        wr = (len >= k) && (word_idx >= k);
      end else if (o <= OP_OMIT_LAST_HI) begin
        k = o - OMIT_LAST_BIAS;
        wr = (len >= k) && (word_idx < len - k);
      end
    end
    r.out_valid = wr;
    r.out_byte = wr ? ob : 8'd0;
    r.out_pos = wr ? pos : 7'd0;
    if (wr) pos = pos + 7'd1;
    r.word_end = last;
    r.final_len = last ? pos : 7'd0;
    next_pos = pos;
    word_idx = last ? 5'd0 : word_idx + 5'd1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result transaction %0d)",
             what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic send_item(input logic [4:0] o, input logic [5:0] s, input logic [4:0] w,
                           input logic [7:0] b, input logic use_typed, input result_t typed_exp);
    int      gap;
    result_t predicted;
    gap = send_gaps_on ? $urandom_range(8, 0) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    start_pos <= s;
    word_len <= w;
    src_byte <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = transform_byte(o, s, w, b);
    expected_transforms.push_back(use_typed ? typed_exp : predicted);
  endtask

  initial begin : result_sink
    int      gap;
    result_t want;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = recv_gaps_on ? $urandom_range(8, 0) : 0;
      end
      if ($urandom_range(49, 0) == 0) recv_gaps_on = !recv_gaps_on;
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      results_seen++;
      if (expected_transforms.size() == 0) begin
        report_mismatch("unexpected transaction, out_byte", int'(out_byte), 0);
      end else begin
        want = expected_transforms.pop_front();
        if (out_valid !== want.out_valid)
          report_mismatch("out_valid", int'(out_valid), int'(want.out_valid));
        if (out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(out_byte), int'(want.out_byte));
        if (out_pos !== want.out_pos)
          report_mismatch("out_pos", int'(out_pos), int'(want.out_pos));
        if (word_end !== want.word_end)
          report_mismatch("word_end", int'(word_end), int'(want.word_end));
        if (final_len !== want.final_len)
          report_mismatch("final_len", int'(final_len), int'(want.final_len));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int         random_items;
    int         pick;
    bit         hold_issued;
    bit         drain_issued;
    bit         noisy;
    logic [4:0] w_op;
    logic [5:0] w_start;
    logic [4:0] w_len;
    logic [4:0] i_op;
    logic [4:0] i_len;
    logic [7:0] i_byte;
    random_items = 0;
    hold_issued = 1'b0;
    drain_issued = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].start, dir_rows[i].wlen, dir_rows[i].b,
                dir_rows[i].typed, dir_rows[i].exp);

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 600 && !hold_issued) begin
        // sink holds off, source keeps pushing: fills the block
        hold_issued = 1'b1;
        long_hold_req = 1'b1;
        send_gaps_on = 1'b0;
      end else if (random_items >= 1200 && !drain_issued) begin
        drain_issued = 1'b1;
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_transforms.size() != 0) @(posedge clk);
      end else begin
        send_gaps_on = ($urandom_range(3, 0) != 0);
      end

      pick = $urandom_range(99, 0);
      if (pick < 8) w_op = 5'($urandom_range(OP_UNUSED_HI, OP_OMIT_LAST_HI + 5'd1));
      else if (pick < 24) w_op = OP_UPPER_FIRST;
      else if (pick < 40) w_op = OP_UPPER_ALL;
      else w_op = 5'($urandom_range(OP_OMIT_LAST_HI, 0));
      w_start = ($urandom_range(1, 0) != 0) ? 6'($urandom_range(63, 0)) :
                                              6'($urandom_range(40, 28));
      w_len = ($urandom_range(3, 0) != 0) ? 5'($urandom_range(12, 1)) :
                                            5'($urandom_range(31, 13));
      noisy = ($urandom_range(9, 0) == 0);

      do begin
        i_op = w_op;
        i_len = w_len;
        if (noisy && $urandom_range(2, 0) == 0) begin
          i_op = 5'($urandom_range(31, 0));
          i_len = 5'($urandom_range(31, 0));
        end
        pick = $urandom_range(9, 0);
        if (pick < 3) i_byte = 8'($urandom_range(LOWER_Z, LOWER_A));
        else if (pick < 5) i_byte = 8'($urandom_range(LEAD_THREE - 8'd1, LEAD_TWO));
        else if (pick < 7) i_byte = 8'($urandom_range(255, LEAD_THREE));
        else i_byte = 8'($urandom_range(255, 0));
        send_item(i_op, w_start, i_len, i_byte, 1'b0, '0);
        random_items++;
      end while (word_idx != 5'd0);
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_transforms.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
